// ===== sv/fvn_pkg.sv =====
package fvn_pkg;

  localparam int FRAC     = 16;
  localparam int FRAC_ONE = 65536;
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 3;
  localparam int MUL_W    = 34;
  localparam int PROD_W   = 64;

  localparam logic [IDX_W-1:0] REG_PERSISTENCE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_BASE_FREQUENCY = 3'd1;
  localparam logic [IDX_W-1:0] REG_AMPLITUDE      = 3'd2;
  localparam logic [IDX_W-1:0] REG_OCTAVE_COUNT   = 3'd3;
  localparam logic [IDX_W-1:0] REG_SEED           = 3'd4;

  localparam logic [16:0] PERSISTENCE_RST    = 17'd32768;
  localparam logic [23:0] BASE_FREQUENCY_RST = 24'd65536;
  localparam logic [31:0] AMPLITUDE_RST      = 32'd65536;
  localparam logic [3:0]  OCTAVE_COUNT_RST   = 4'd4;
  localparam logic [9:0]  SEED_RST           = 10'd0;

  localparam logic [31:0] HASH_MUL = 32'd15731;
  localparam logic [31:0] HASH_ADD = 32'd789221;
  localparam logic [31:0] HASH_OFF = 32'd1376312589;
  localparam logic [31:0] POS_MAX  = 32'h7fffffff;
  localparam logic [31:0] NEG_MAX  = 32'h80000000;

  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  typedef struct packed {
    logic [16:0]        persistence;
    logic [23:0]        base_frequency;
    logic signed [31:0] amplitude;
    logic [3:0]         octave_count;
    logic [9:0]         seed;
  } cfg_t;

endpackage

// ===== sv/fvn_front.sv =====
module fvn_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  fvn_pkg::item_t       item,
  output logic                 busy,
  output fvn_pkg::qhead_t      head,
  input  logic                 pop
);
  import fvn_pkg::*;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign busy = (count == 2'd2);
  assign push = start && !busy;
  assign head.valid = (count != 2'd0);
  assign head.item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/fvn_mul.sv =====
module fvn_mul (
  input  logic                               clk,
  input  logic signed [fvn_pkg::MUL_W-1:0]   a,
  input  logic signed [fvn_pkg::MUL_W-1:0]   b,
  output logic signed [fvn_pkg::PROD_W-1:0]  prod
);
  import fvn_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a * b);
  end

endmodule

// ===== sv/fvn_back.sv =====
module fvn_back #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  fvn_pkg::qhead_t                    head,
  output logic                               pop,
  input  fvn_pkg::cfg_t                      cfg,
  output logic signed [fvn_pkg::MUL_W-1:0]   mul_a,
  output logic signed [fvn_pkg::MUL_W-1:0]   mul_b,
  input  logic signed [fvn_pkg::PROD_W-1:0]  prod,
  output logic                               done,
  output logic signed [31:0]                 height,
  output logic                               saturated
);
  import fvn_pkg::*;

  localparam int OW = $clog2(MAX_OCTAVES + 1);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_PX   = 13'b0000000000010,
    S_PY   = 13'b0000000000100,
    S_OFF  = 13'b0000000001000,
    S_LOAD = 13'b0000000010000,
    S_OCT  = 13'b0000000100000,
    S_H0   = 13'b0000001000000,
    S_H1   = 13'b0000010000000,
    S_H2   = 13'b0000100000000,
    S_H3   = 13'b0001000000000,
    S_CORN = 13'b0010000000000,
    S_MATH = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_t;

  state_t state;

  logic signed [31:0] x_r, y_r;
  logic signed [55:0] px, py;
  logic [36:0]        off;
  logic [OW-1:0]      oct;
  logic [OW-1:0]      oct_inc;
  logic [OW-1:0]      n_oct;
  logic [31:0]        ix, iy;
  logic signed [16:0] fx, fy;
  logic [3:0]         hidx;
  logic [31:0]        hn;
  logic signed [17:0] lat [16];
  logic signed [17:0] c00, c01, c10, c11;
  logic [4:0]         ms;
  logic [1:0]         fs;
  logic signed [19:0] t2;
  logic signed [23:0] gbx, gax, gby, gay;
  logic signed [23:0] top, bot;
  logic signed [47:0] acc;
  logic signed [31:0] sum;
  logic [16:0]        weight;

  logic [4:0]         sh;
  logic signed [55:0] psx, psy;
  logic signed [56:0] gx, gy;
  logic               gx_nf, gy_nf;
  logic [31:0]        iv, jv, n0, nh, tv;
  logic signed [47:0] p48;
  logic signed [19:0] sq;
  logic signed [23:0] gv;
  logic signed [27:0] blw;
  logic signed [18:0] sbx, sby;
  logic               neg;
  logic [31:0]        mt, ma;
  logic [48:0]        lo, mag;

  function automatic logic signed [17:0] corner(
    input logic signed [17:0] g00, input logic signed [17:0] g01,
    input logic signed [17:0] g02, input logic signed [17:0] g10,
    input logic signed [17:0] g11, input logic signed [17:0] g12,
    input logic signed [17:0] g20, input logic signed [17:0] g21,
    input logic signed [17:0] g22);
    logic signed [21:0] s;
    s = 22'(g00) + 22'(g02) + 22'(g20) + 22'(g22)
      + ((22'(g01) + 22'(g10) + 22'(g12) + 22'(g21)) <<< 1)
      + (22'(g11) <<< 2);
    return 18'(s >>> 4);
  endfunction

  assign pop     = (state == S_IDLE) && head.valid;
  assign n_oct   = (int'(cfg.octave_count) < MAX_OCTAVES) ? OW'(cfg.octave_count)
                                                          : OW'(MAX_OCTAVES);
  assign oct_inc = oct + OW'(1);

  assign sh    = 5'(FRAC) - 5'(oct);
  assign psx   = px >>> sh;
  assign psy   = py >>> sh;
  assign gx    = 57'(psy) + 57'(off);
  assign gy    = 57'(psx) + 57'(off);
  assign gx_nf = gx[56] && (gx[15:0] != 16'd0);
  assign gy_nf = gy[56] && (gy[15:0] != 16'd0);

  assign iv = ix + 32'(hidx[1:0]) - 32'd1;
  assign jv = iy + 32'(hidx[3:2]) - 32'd1;
  assign n0 = iv + (jv << 6) - (jv << 3) + jv;
  assign nh = (n0 << 13) ^ n0;
  assign tv = prod[31:0] + HASH_OFF;

  assign p48 = prod[47:0];
  assign sq  = 20'(p48 >>> 16);
  assign gv  = 24'(t2 * 3 - (p48 >>> 16) * 2);
  assign blw = 28'((acc + p48) >>> 16);
  assign sbx = 19'(FRAC_ONE) - 19'(fx);
  assign sby = 19'(FRAC_ONE) - 19'(fy);

  assign neg = sum[31] != cfg.amplitude[31];
  assign mt  = sum[31] ? 32'(-sum) : 32'(sum);
  assign ma  = cfg.amplitude[31] ? 32'(-cfg.amplitude) : 32'(cfg.amplitude);
  assign lo  = (49'(p48) + (neg ? 49'(FRAC_ONE - 1) : 49'd0)) >> 16;
  assign mag = 49'(acc) + lo;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_PX: begin
        mul_a = MUL_W'(x_r);
        mul_b = MUL_W'(cfg.base_frequency);
      end
      S_PY: begin
        mul_a = MUL_W'(y_r);
        mul_b = MUL_W'(cfg.base_frequency);
      end
      S_OFF: begin
        mul_a = MUL_W'(cfg.seed);
        mul_b = MUL_W'(cfg.seed);
      end
      S_H0: begin
        mul_a = MUL_W'(nh);
        mul_b = MUL_W'(nh);
      end
      S_H1: begin
        mul_a = MUL_W'(prod[31:0]);
        mul_b = MUL_W'(HASH_MUL);
      end
      S_H2: begin
        mul_a = MUL_W'(hn);
        mul_b = MUL_W'(prod[31:0] + HASH_ADD);
      end
      S_MATH: begin
        unique case (ms)
          5'd0:  begin mul_a = MUL_W'(sbx);    mul_b = MUL_W'(sbx);  end
          5'd1:  begin mul_a = MUL_W'(sq);     mul_b = MUL_W'(sbx);  end
          5'd2:  begin mul_a = MUL_W'(fx);     mul_b = MUL_W'(fx);   end
          5'd3:  begin mul_a = MUL_W'(sq);     mul_b = MUL_W'(fx);   end
          5'd4:  begin mul_a = MUL_W'(sby);    mul_b = MUL_W'(sby);  end
          5'd5:  begin mul_a = MUL_W'(sq);     mul_b = MUL_W'(sby);  end
          5'd6:  begin mul_a = MUL_W'(fy);     mul_b = MUL_W'(fy);   end
          5'd7:  begin mul_a = MUL_W'(sq);     mul_b = MUL_W'(fy);   end
          5'd8:  begin mul_a = MUL_W'(c00);    mul_b = MUL_W'(gbx);  end
          5'd9:  begin mul_a = MUL_W'(c01);    mul_b = MUL_W'(gax);  end
          5'd10: begin mul_a = MUL_W'(c10);    mul_b = MUL_W'(gbx);  end
          5'd11: begin mul_a = MUL_W'(c11);    mul_b = MUL_W'(gax);  end
          5'd12: begin mul_a = MUL_W'(top);    mul_b = MUL_W'(gby);  end
          5'd13: begin mul_a = MUL_W'(bot);    mul_b = MUL_W'(gay);  end
          5'd14: begin mul_a = MUL_W'(blw);    mul_b = MUL_W'(weight); end
          5'd15: begin mul_a = MUL_W'(weight); mul_b = MUL_W'(cfg.persistence); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_FIN: begin
        unique case (fs)
          2'd0:    begin mul_a = MUL_W'(ma); mul_b = MUL_W'(mt[31:16]); end
          2'd1:    begin mul_a = MUL_W'(ma); mul_b = MUL_W'(mt[15:0]);  end
          default: begin mul_a = '0;         mul_b = '0;                end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            x_r    <= head.item.coord_x;
            y_r    <= head.item.coord_y;
            sum    <= '0;
            weight <= 17'(FRAC_ONE);
            oct    <= '0;
            state  <= S_PX;
          end
        end
        S_PX: state <= S_PY;
        S_PY: begin
          px    <= prod[55:0];
          state <= S_OFF;
        end
        S_OFF: begin
          py    <= prod[55:0];
          state <= S_LOAD;
        end
        S_LOAD: begin
          off <= {21'(prod[19:0]) + 21'd2, 16'd0};
          fs  <= 2'd0;
          if (n_oct == '0) begin
            state <= S_FIN;
          end else begin
            state <= S_OCT;
          end
        end
        S_OCT: begin
          ix    <= gx_nf ? gx[47:16] + 32'd1 : gx[47:16];
          iy    <= gy_nf ? gy[47:16] + 32'd1 : gy[47:16];
          fx    <= {gx_nf, gx[15:0]};
          fy    <= {gy_nf, gy[15:0]};
          hidx  <= 4'd0;
          state <= S_H0;
        end
        S_H0: begin
          hn    <= nh;
          state <= S_H1;
        end
        S_H1: state <= S_H2;
        S_H2: state <= S_H3;
        S_H3: begin
          lat[hidx] <= 18'(FRAC_ONE) - 18'(tv[30:14]);
          hidx      <= hidx + 4'd1;
          if (hidx == 4'd15) begin
            state <= S_CORN;
          end else begin
            state <= S_H0;
          end
        end
        S_CORN: begin
          c00   <= corner(lat[0], lat[1], lat[2], lat[4], lat[5], lat[6],
                          lat[8], lat[9], lat[10]);
          c01   <= corner(lat[1], lat[2], lat[3], lat[5], lat[6], lat[7],
                          lat[9], lat[10], lat[11]);
          c10   <= corner(lat[4], lat[5], lat[6], lat[8], lat[9], lat[10],
                          lat[12], lat[13], lat[14]);
          c11   <= corner(lat[5], lat[6], lat[7], lat[9], lat[10], lat[11],
                          lat[13], lat[14], lat[15]);
          ms    <= 5'd0;
          state <= S_MATH;
        end
        S_MATH: begin
          ms <= ms + 5'd1;
          unique case (ms)
            5'd1, 5'd3, 5'd5, 5'd7: t2 <= sq;
            5'd2:  gbx <= gv;
            5'd4:  gax <= gv;
            5'd6:  gby <= gv;
            5'd8:  gay <= gv;
            5'd9, 5'd11, 5'd13: acc <= p48;
            5'd10: top <= 24'(blw);
            5'd12: bot <= 24'(blw);
            5'd15: sum <= sum + 32'(p48 >>> 16);
            5'd16: begin
              weight <= prod[32:16];
              oct    <= oct_inc;
              fs     <= 2'd0;
              if (oct_inc == n_oct) begin
                state <= S_FIN;
              end else begin
                state <= S_OCT;
              end
            end
            default: ;
          endcase
        end
        S_FIN: begin
          fs <= fs + 2'd1;
          unique case (fs)
            2'd1: acc <= p48;
            2'd2: begin
              done <= 1'b1;
              if (!neg) begin
                saturated <= mag > 49'(POS_MAX);
                height    <= (mag > 49'(POS_MAX)) ? POS_MAX : mag[31:0];
              end else begin
                saturated <= mag > 49'(NEG_MAX);
                height    <= (mag > 49'(NEG_MAX)) ? NEG_MAX : 32'(-mag[31:0]);
              end
              state <= S_IDLE;
            end
            default: ;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/fractal_value_noise_height.sv =====
// channel   ports                        handshake
// input     coord_x, coord_y             start high, busy low
// result    height, saturated            done high for one cycle
// config    wr_en, wr_index, wr_data     wr_en high, no wait
//
// An item's work from leaving the queue to done runs through the single
// shared multiplier: sixteen lattice hashes of four steps each, then
// seventeen smoothing and weighting steps per octave.
// A two-word queue takes new items while one is at work; busy means it is full.
// Reset is synchronous and empties the queue; results cannot be held off.
module fractal_value_noise_height #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [31:0]            coord_x,
  input  logic signed [31:0]            coord_y,
  output logic                          done,
  output logic signed [31:0]            height,
  output logic                          saturated,
  input  logic                          wr_en,
  input  logic [fvn_pkg::IDX_W-1:0]     wr_index,
  input  logic [fvn_pkg::CFG_W-1:0]     wr_data
);
  import fvn_pkg::*;

  cfg_t                      cfg;
  item_t                     item;
  qhead_t                    head;
  logic                      pop;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;

  assign item.coord_x = coord_x;
  assign item.coord_y = coord_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.persistence    <= PERSISTENCE_RST;
      cfg.base_frequency <= BASE_FREQUENCY_RST;
      cfg.amplitude      <= AMPLITUDE_RST;
      cfg.octave_count   <= OCTAVE_COUNT_RST;
      cfg.seed           <= SEED_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PERSISTENCE:    cfg.persistence    <= wr_data[16:0];
        REG_BASE_FREQUENCY: cfg.base_frequency <= wr_data[23:0];
        REG_AMPLITUDE:      cfg.amplitude      <= wr_data[31:0];
        REG_OCTAVE_COUNT:   cfg.octave_count   <= wr_data[3:0];
        REG_SEED:           cfg.seed           <= wr_data[9:0];
        default: ;
      endcase
    end
  end

  fvn_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .head  (head),
    .pop   (pop)
  );

  fvn_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  fvn_back #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .cfg       (cfg),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .prod      (prod),
    .done      (done),
    .height    (height),
    .saturated (saturated)
  );

endmodule
